// ===== hdl/mnpd_pkg.sv =====
// ----------------------------------------------------------------------------
// mnpd_pkg: shared types and constants of the closest nonzero pair block
// Capacity, field widths, request structs and the point memory address map.
// ----------------------------------------------------------------------------
`default_nettype none

package mnpd_pkg;

    // capacity of the point memory
    localparam int MAX_POINTS = 256;
    localparam int MAX_DIMS   = 8;

    // field widths
    localparam int COORD_W = 16;
    localparam int DIMS_W  = 4;
    localparam int DIST_W  = 35;

    // derived widths
    localparam int PT_W   = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int PL_W   = $clog2(MAX_POINTS + 1);
    localparam int CIDX_W = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
    localparam int CNT_W  = $clog2(MAX_DIMS + 1);
    localparam int DCMP_W = (CNT_W > DIMS_W) ? CNT_W : DIMS_W;
    localparam int ADDR_W = $clog2(MAX_POINTS * MAX_DIMS);
    localparam int SQ_W   = 2 * COORD_W;
    localparam int BEST_W = SQ_W + ((MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 0);
    localparam int CMP_W  = (BEST_W > DIST_W) ? BEST_W : DIST_W;

    // register reset and result saturation
    localparam logic [DIMS_W-1:0] DIMS_RESET = DIMS_W'(2);
    localparam logic [DIST_W-1:0] DIST_MAX   = {DIST_W{1'b1}};

    // input request
    typedef struct packed {
        logic signed [COORD_W-1:0] coord;
        logic                      last;
    } t_in;

    // output request
    typedef struct packed {
        logic [DIST_W-1:0] min_dist_sq;
        logic              found;
        logic              overflowed;
    } t_out;

    // read issued to the distance unit, aligned with the memory address
    typedef struct packed {
        logic              valid;
        logic              load;
        logic              first;
        logic              last;
        logic [CIDX_W-1:0] c;
    } t_dist_ctl;

    // point-major address: one row of MAX_DIMS coordinates per point
    function automatic logic [ADDR_W-1:0] mnpd_addr(
        input logic [PT_W-1:0]   pt,
        input logic [CIDX_W-1:0] c
    );
        mnpd_addr = ADDR_W'(ADDR_W'(pt) * ADDR_W'(MAX_DIMS)) + ADDR_W'(c);
    endfunction

endpackage

`default_nettype wire

// ===== hdl/mnpd_ram.sv =====
// ----------------------------------------------------------------------------
// mnpd_ram: generic simple dual-port memory
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module mnpd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2048
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== hdl/mnpd_dist_unit.sv =====
// ----------------------------------------------------------------------------
// mnpd_dist_unit: shared difference, square and accumulate pipeline
// Buffers the first point of a pair, streams the second point one coordinate
// a cycle, and keeps the smallest nonzero squared distance.
// ----------------------------------------------------------------------------
`default_nettype none

module mnpd_dist_unit (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire mnpd_pkg::t_dist_ctl                  i_ctl,
    input  wire logic signed [mnpd_pkg::COORD_W-1:0] i_rdata,
    input  wire logic                                 i_clear_best,
    output logic             [mnpd_pkg::BEST_W-1:0]  o_best,
    output logic                                      o_busy
);

    import mnpd_pkg::*;

    t_dist_ctl                 r_s1;
    t_dist_ctl                 r_s2c;
    t_dist_ctl                 r_s3c;
    logic signed [COORD_W-1:0] r_abuf [MAX_DIMS];
    logic        [COORD_W-1:0] r_s2_mag;
    logic        [SQ_W-1:0]    r_sq;
    logic        [BEST_W-1:0]  r_acc;
    logic        [BEST_W-1:0]  r_pair;
    logic                      r_pv;
    logic        [BEST_W-1:0]  r_best;

    logic signed [COORD_W:0]   diff;
    logic        [COORD_W:0]   mag;
    logic        [BEST_W-1:0]  n_acc;
    t_dist_ctl                 s2_ctl;

    // stage 1: coordinate difference against the buffered point
    always_comb begin
        diff = {r_abuf[r_s1.c][COORD_W-1], r_abuf[r_s1.c]} - {i_rdata[COORD_W-1], i_rdata};
        mag  = diff[COORD_W] ? (COORD_W+1)'(-diff) : diff;
    end

    // buffer loads stop at stage 1
    always_comb begin
        s2_ctl       = r_s1;
        s2_ctl.valid = r_s1.valid && !r_s1.load;
    end

    // stage 3: running sum over the coordinates of one pair
    assign n_acc = (r_s3c.first ? '0 : r_acc) + BEST_W'(r_sq);

    // control pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1  <= '0;
            r_s2c <= '0;
            r_s3c <= '0;
            r_pv  <= 1'b0;
        end else begin
            r_s1  <= i_ctl;
            r_s2c <= s2_ctl;
            r_s3c <= r_s2c;
            r_pv  <= r_s3c.valid && r_s3c.last;
        end
    end

    // data pipeline
    always_ff @(posedge i_clk) begin
        if (r_s1.valid && r_s1.load) begin
            r_abuf[r_s1.c] <= i_rdata;
        end
        r_s2_mag <= mag[COORD_W-1:0];
        r_sq     <= SQ_W'(r_s2_mag) * SQ_W'(r_s2_mag);
        if (r_s3c.valid) begin
            r_acc <= n_acc;
        end
        r_pair <= n_acc;
    end

    // running minimum over nonzero pair distances
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_best <= '0;
        end else if (i_clear_best) begin
            r_best <= '0;
        end else if (r_pv && r_pair != '0 && (r_best == '0 || r_pair < r_best)) begin
            r_best <= r_pair;
        end
    end

    assign o_best = r_best;
    assign o_busy = r_s1.valid || r_s2c.valid || r_s3c.valid || r_pv;

    // a minimum once found only shrinks until the next pass clears it
    a_best_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_best != '0 && !i_clear_best) |=> (r_best != '0 && r_best <= $past(r_best)))
        else $error("best distance grew or vanished without a clear");

    // buffer loads never enter the squaring stage
    a_load_no_square: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1.valid && r_s1.load) |=> !r_s2c.valid)
        else $error("buffer load leaked into the distance pipeline");

    // a pair result follows its last coordinate
    a_pair_from_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pv |-> $past(r_s3c.valid && r_s3c.last))
        else $error("pair result without a last coordinate");

endmodule

`default_nettype wire

// ===== hdl/min_nonzero_pair_distance.sv =====
// ----------------------------------------------------------------------------
// min_nonzero_pair_distance: smallest nonzero squared distance of a point set
// Loads points one coordinate per request, then compares all pairs with one
// shared distance pipeline and returns the smallest nonzero distance.
// ----------------------------------------------------------------------------
// Usage
//   input channel  i_valid / o_stall / i_data: one coordinate per request;
//     the request with last set closes the point set and starts the pass
//   output channel o_valid / i_stall / o_data: one result per closed set
//   config channel i_cfg_valid / o_cfg_ready / i_cfg_data: coordinates per
//     point; the user writes it only while the block is idle, and the block
//     does not enforce this (0 acts as 1, above 8 as 8)
//   Loading takes one coordinate per cycle; a point that completes with fewer
//   than 8 coordinates stalls input while its unused memory slots are zeroed.
//   The pass reads the point memory through its single read port: it buffers
//   each first point, then streams every later point against it.
//   o_stall is high from the last request until the result is taken; while
//   i_stall holds the result, o_data stays unchanged and no request enters.
//   Reset clears the counters and restores d = 2; the point memory is not
//   cleared, since every slot is written before it is read.
// ----------------------------------------------------------------------------
`default_nettype none

module min_nonzero_pair_distance (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_stall,
    input  wire mnpd_pkg::t_in                 i_data,
    output logic                               o_valid,
    input  wire logic                          i_stall,
    output mnpd_pkg::t_out                     o_data,
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [mnpd_pkg::DIMS_W-1:0]   i_cfg_data
);

    import mnpd_pkg::*;

    typedef enum logic [6:0] {
        S_LOAD  = 7'b0000001,
        S_FILL  = 7'b0000010,
        S_PASS  = 7'b0000100,
        S_LOADA = 7'b0001000,
        S_SCAN  = 7'b0010000,
        S_DRAIN = 7'b0100000,
        S_OUT   = 7'b1000000
    } t_state;

    t_state             r_state, n_state;
    logic [DIMS_W-1:0]  r_dims;
    logic [CIDX_W-1:0]  r_cip, n_cip;
    logic [PL_W-1:0]    r_pl, n_pl;
    logic               r_drop, n_drop;
    logic [PT_W-1:0]    r_fpt, n_fpt;
    logic [CIDX_W-1:0]  r_fc, n_fc;
    logic               r_lastp, n_lastp;
    logic [PT_W-1:0]    r_pa, n_pa;
    logic [PT_W-1:0]    r_pb, n_pb;
    logic [CIDX_W-1:0]  r_c, n_c;
    t_out               r_out, n_out;

    logic               in_acc;
    logic [CNT_W-1:0]   eff_d;
    logic [CNT_W-1:0]   cip_inc;
    logic               complete;
    logic               room;
    logic               c_last;
    logic [PT_W-1:0]    pl_pt;
    logic               ram_we;
    logic [ADDR_W-1:0]  ram_waddr;
    logic [ADDR_W-1:0]  ram_raddr;
    logic [COORD_W-1:0] ram_wdata;
    logic [COORD_W-1:0] ram_rdata;
    t_dist_ctl          ctl;
    logic               clear_best;
    logic [BEST_W-1:0]  best;
    logic               dp_busy;

    // config register
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dims <= DIMS_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_dims <= i_cfg_data;
        end
    end

    // effective dimension count
    always_comb begin
        if (r_dims == '0) begin
            eff_d = CNT_W'(1);
        end else if (DCMP_W'(r_dims) > DCMP_W'(MAX_DIMS)) begin
            eff_d = CNT_W'(MAX_DIMS);
        end else begin
            eff_d = CNT_W'(r_dims);
        end
    end

    // handshake and load helpers
    assign o_stall  = (r_state != S_LOAD);
    assign in_acc   = i_valid && !o_stall;
    assign o_valid  = (r_state == S_OUT);
    assign o_data   = r_out;
    assign cip_inc  = CNT_W'(r_cip) + CNT_W'(1);
    assign complete = (cip_inc >= eff_d);
    assign room     = (r_pl < PL_W'(MAX_POINTS));
    assign c_last   = (CNT_W'(r_c) == eff_d - CNT_W'(1));
    assign pl_pt    = r_pl[PT_W-1:0];

    // sequencer
    always_comb begin
        n_state    = r_state;
        n_cip      = r_cip;
        n_pl       = r_pl;
        n_drop     = r_drop;
        n_fpt      = r_fpt;
        n_fc       = r_fc;
        n_lastp    = r_lastp;
        n_pa       = r_pa;
        n_pb       = r_pb;
        n_c        = r_c;
        n_out      = r_out;
        ram_we     = 1'b0;
        ram_waddr  = mnpd_addr(pl_pt, r_cip);
        ram_wdata  = i_data.coord;
        ram_raddr  = mnpd_addr(r_pa, r_c);
        ctl        = '0;
        clear_best = 1'b0;
        unique case (r_state)
            S_LOAD: begin
                if (in_acc) begin
                    ram_we = room;
                    if (complete) begin
                        n_cip = '0;
                        if (room) begin
                            n_pl = r_pl + PL_W'(1);
                        end else begin
                            n_drop = 1'b1;
                        end
                    end else begin
                        n_cip = cip_inc[CIDX_W-1:0];
                    end
                    // a short point gets its unused slots zeroed
                    if (complete && room && cip_inc < CNT_W'(MAX_DIMS)) begin
                        n_fpt   = pl_pt;
                        n_fc    = cip_inc[CIDX_W-1:0];
                        n_lastp = i_data.last;
                        n_state = S_FILL;
                    end else if (i_data.last) begin
                        n_state = S_PASS;
                    end
                end
            end
            S_FILL: begin
                ram_we    = 1'b1;
                ram_waddr = mnpd_addr(r_fpt, r_fc);
                ram_wdata = '0;
                if (CNT_W'(r_fc) == CNT_W'(MAX_DIMS - 1)) begin
                    n_state = r_lastp ? S_PASS : S_LOAD;
                end else begin
                    n_fc = r_fc + CIDX_W'(1);
                end
            end
            S_PASS: begin
                clear_best = 1'b1;
                n_pa       = '0;
                n_c        = '0;
                n_state    = (r_pl < PL_W'(2)) ? S_DRAIN : S_LOADA;
            end
            S_LOADA: begin
                // buffer the first point of the pair row
                ctl.valid = 1'b1;
                ctl.load  = 1'b1;
                ctl.c     = r_c;
                ram_raddr = mnpd_addr(r_pa, r_c);
                if (c_last) begin
                    n_c     = '0;
                    n_pb    = r_pa + PT_W'(1);
                    n_state = S_SCAN;
                end else begin
                    n_c = r_c + CIDX_W'(1);
                end
            end
            S_SCAN: begin
                // stream the second point against the buffer
                ctl.valid = 1'b1;
                ctl.first = (r_c == '0);
                ctl.last  = c_last;
                ctl.c     = r_c;
                ram_raddr = mnpd_addr(r_pb, r_c);
                if (c_last) begin
                    n_c = '0;
                    if (PL_W'(r_pb) == r_pl - PL_W'(1)) begin
                        if (PL_W'(r_pa) == r_pl - PL_W'(2)) begin
                            n_state = S_DRAIN;
                        end else begin
                            n_pa    = r_pa + PT_W'(1);
                            n_state = S_LOADA;
                        end
                    end else begin
                        n_pb = r_pb + PT_W'(1);
                    end
                end else begin
                    n_c = r_c + CIDX_W'(1);
                end
            end
            S_DRAIN: begin
                if (!dp_busy) begin
                    n_out.min_dist_sq = (CMP_W'(best) > CMP_W'(DIST_MAX)) ?
                                        DIST_MAX : DIST_W'(best);
                    n_out.found       = (best != '0);
                    n_out.overflowed  = r_drop;
                    n_state           = S_OUT;
                end
            end
            S_OUT: begin
                if (!i_stall) begin
                    n_pl    = '0;
                    n_cip   = '0;
                    n_drop  = 1'b0;
                    n_state = S_LOAD;
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_cip   <= '0;
            r_pl    <= '0;
            r_drop  <= 1'b0;
            r_fpt   <= '0;
            r_fc    <= '0;
            r_lastp <= 1'b0;
            r_pa    <= '0;
            r_pb    <= '0;
            r_c     <= '0;
        end else begin
            r_state <= n_state;
            r_cip   <= n_cip;
            r_pl    <= n_pl;
            r_drop  <= n_drop;
            r_fpt   <= n_fpt;
            r_fc    <= n_fc;
            r_lastp <= n_lastp;
            r_pa    <= n_pa;
            r_pb    <= n_pb;
            r_c     <= n_c;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    // point memory
    mnpd_ram #(
        .WIDTH (COORD_W),
        .DEPTH (MAX_POINTS * MAX_DIMS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // shared distance unit
    mnpd_dist_unit u_dist (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (ctl),
        .i_rdata      (ram_rdata),
        .i_clear_best (clear_best),
        .o_best       (best),
        .o_busy       (dp_busy)
    );

    // second point of a pair always follows the first
    a_pair_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_pb > r_pa))
        else $error("pair scan with second index not above first");

    // result shown only after the pipeline has drained
    a_out_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT) |-> !dp_busy)
        else $error("result presented while distances still in flight");

    // point count never exceeds capacity
    a_pl_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pl <= PL_W'(MAX_POINTS))
        else $error("point count beyond capacity");

    // found flag agrees with the distance
    a_found_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT) |-> (r_out.found == (r_out.min_dist_sq != '0)))
        else $error("found flag disagrees with distance");

endmodule

`default_nettype wire
